// ----- rtl/core/mrb_pkg.sv -----
// mailbox register block package: beat types, controller/datapath command and
// status structs, register offsets and status codes
// no dependencies
package mrb_pkg;

    localparam int OFFSET_W = 13;
    localparam int SIZE_W   = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ADDR_W   = OFFSET_W + 1;  // byte address of a lane, may run past the offset range
    localparam int LIM_W    = 17;            // holds the largest window size

    localparam int WINDOW_BYTES_DEF = 4096;
    localparam int FIFO_DEPTH_DEF   = 16;

    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FAULT = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    localparam logic [OFFSET_W-1:0] OFS_TXCMD   = 13'h004;
    localparam logic [OFFSET_W-1:0] OFS_CMD     = 13'h00C;
    localparam logic [OFFSET_W-1:0] OFS_CMD_EXT = 13'h010;
    localparam logic [ADDR_W-1:0]   ADR_CFG_END = 14'h004;  // bytes below this form the key word
    localparam logic [ADDR_W-1:0]   ADR_PEND    = 14'h020;

    localparam int BIT_CMD     = 2;
    localparam int BIT_CMD_EXT = 3;

    localparam logic [WORD_W-1:0] SEND_KEY = 32'hC60A100C;

    typedef struct packed {
        logic                op;
        logic [OFFSET_W-1:0] offset;
        logic [SIZE_W-1:0]   size_bytes;
        logic [WORD_W-1:0]   write_data;
    } t_in_beat;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [WORD_W-1:0]   read_data;
        logic                irq_cmd;
        logic                irq_cmd_ext;
        logic                send_valid;
        logic [WORD_W-1:0]   send_word;
    } t_out_beat;

    typedef struct packed {
        logic clear;   // clearing pass, one row of every bank
        logic accept;  // take the input beat, issue bank and fifo reads
        logic commit;  // apply the access and load the result register
    } t_mrb_cmd;

    typedef struct packed {
        logic clr_last;
    } t_mrb_stat;

endpackage

// ----- rtl/core/mrb_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
module mrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- rtl/core/mrb_fifo.sv -----
// word fifo on a generic ram: head prefetch read, push and pop pointers, fill count
// depends on mrb_pkg and mrb_ram
module mrb_fifo #(
    parameter int DEPTH = mrb_pkg::FIFO_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic                          i_push,
    input  logic                          i_pop,
    input  logic [mrb_pkg::WORD_W-1:0]    i_push_data,
    output logic [mrb_pkg::WORD_W-1:0]    o_head_data,
    output logic [$clog2(DEPTH+1)-1:0]    o_count
);
    import mrb_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [PW-1:0] r_head, n_head;
    logic [PW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (i_push) begin
            n_tail = (r_tail == LAST) ? '0 : r_tail + 1'b1;
        end
        if (i_pop) begin
            n_head = (r_head == LAST) ? '0 : r_head + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    mrb_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_push),
        .i_wr_addr (r_tail),
        .i_wr_data (i_push_data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (r_head),
        .o_rd_data (o_head_data)
    );

    assign o_count = r_count;
endmodule

// ----- rtl/core/mrb_ctrl.sv -----
// mailbox controller: clearing pass, accept and commit sequencing, result valid
// depends on mrb_pkg
module mrb_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    input  mrb_pkg::t_mrb_stat i_stat,
    output mrb_pkg::t_mrb_cmd  o_cmd
);
    import mrb_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   commit;

    assign commit = (r_state == S_EXEC) && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (commit) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.clear  = (r_state == S_CLEAR);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.commit = commit;
    assign o_in_stall   = (r_state != S_IDLE);
    assign o_out_valid  = r_out_valid;
endmodule

// ----- rtl/core/mrb_datapath.sv -----
// mailbox datapath: four byte-lane window banks, key and pending overlays,
// two command fifos, result register
// depends on mrb_pkg, mrb_ram and mrb_fifo
module mrb_datapath #(
    parameter int WINDOW_BYTES = mrb_pkg::WINDOW_BYTES_DEF,
    parameter int FIFO_DEPTH   = mrb_pkg::FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mrb_pkg::t_mrb_cmd  i_cmd,
    output mrb_pkg::t_mrb_stat o_stat,
    input  mrb_pkg::t_in_beat  i_in_data,
    output mrb_pkg::t_out_beat o_out_data
);
    import mrb_pkg::*;

    localparam int ROWS = (WINDOW_BYTES + 3) / 4;
    localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW   = $clog2(FIFO_DEPTH + 1);
    localparam logic [LIM_W-1:0] WIN_LIM  = LIM_W'(WINDOW_BYTES);
    localparam logic [CW-1:0]    FULL_CNT = CW'(FIFO_DEPTH);

    function automatic logic [ADDR_W-1:0] byte_addr(input logic [OFFSET_W-1:0] ofs,
                                                    input logic [1:0] lane);
        return {1'b0, ofs} + ADDR_W'(lane);
    endfunction

    function automatic logic [RW-1:0] row_of(input logic [ADDR_W-1:0] adr);
        logic [15:0] wide;
        wide = 16'(adr[ADDR_W-1:2]);
        return wide[RW-1:0];
    endfunction

    function automatic logic in_window(input logic [ADDR_W-1:0] adr);
        return {{(LIM_W-ADDR_W){1'b0}}, adr} < WIN_LIM;
    endfunction

    t_in_beat        r_item;
    logic [RW-1:0]   r_clr_row;
    logic [WORD_W-1:0] r_cfg_word, n_cfg_word;
    logic [7:0]      r_pend_byte, n_pend_byte;
    t_out_beat       r_out, n_out;

    logic [RW-1:0]   rd_row  [4];
    logic            bank_we [4];
    logic [RW-1:0]   bank_wa [4];
    logic [7:0]      bank_wd [4];
    logic [7:0]      bank_rd [4];

    logic [SIZE_W-1:0] n_eff;
    logic            is_write, item_in_win, hit_cmd, hit_ext, hit_tx;
    logic [ADDR_W-1:0] g_addr [4];
    logic [3:0]      g_en;
    logic [WORD_W-1:0] gathered, wmask, wdata;

    logic [WORD_W-1:0] cmd_head, ext_head;
    logic [CW-1:0]   cmd_fill, ext_fill;
    logic            cmd_push, cmd_pop, ext_push, ext_pop;
    logic            cmd_empty, ext_empty, cmd_full, ext_full;
    logic            cmd_last, ext_last;

    // read rows for the beat being accepted
    always_comb begin
        for (int b = 0; b < 4; b++) begin
            rd_row[b] = row_of(byte_addr(i_in_data.offset, 2'(b) - i_in_data.offset[1:0]));
        end
    end

    assign n_eff       = (r_item.size_bytes > 3'd4) ? 3'd4 : r_item.size_bytes;
    assign is_write    = (r_item.op == OP_WRITE);
    assign item_in_win = in_window({1'b0, r_item.offset});
    assign hit_cmd     = (r_item.offset == OFS_CMD);
    assign hit_ext     = (r_item.offset == OFS_CMD_EXT);
    assign hit_tx      = (r_item.offset == OFS_TXCMD);

    // byte lanes of the held beat, in access order
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            g_addr[i] = byte_addr(r_item.offset, 2'(i));
            g_en[i]   = in_window(g_addr[i]) && ({1'b0, 2'(i)} < n_eff);
            wmask[8*i +: 8] = ({1'b0, 2'(i)} < n_eff) ? 8'hFF : 8'h00;
            if (!g_en[i]) begin
                gathered[8*i +: 8] = 8'h00;
            end else if (g_addr[i] < ADR_CFG_END) begin
                gathered[8*i +: 8] = r_cfg_word[8*g_addr[i][1:0] +: 8];
            end else if (g_addr[i] == ADR_PEND) begin
                gathered[8*i +: 8] = r_pend_byte;
            end else begin
                gathered[8*i +: 8] = bank_rd[2'(r_item.offset[1:0] + 2'(i))];
            end
        end
    end

    assign wdata = r_item.write_data & wmask;

    // bank writes: clearing pass or committed write
    always_comb begin
        logic [1:0]        lane;
        logic [ADDR_W-1:0] adr;
        for (int b = 0; b < 4; b++) begin
            lane = 2'(b) - r_item.offset[1:0];
            adr  = byte_addr(r_item.offset, lane);
            if (i_cmd.clear) begin
                bank_we[b] = 1'b1;
                bank_wa[b] = r_clr_row;
                bank_wd[b] = 8'h00;
            end else begin
                bank_we[b] = i_cmd.commit && is_write && item_in_win && g_en[lane];
                bank_wa[b] = row_of(adr);
                bank_wd[b] = wdata[8*lane +: 8];
            end
        end
    end

    for (genvar b = 0; b < 4; b++) begin : g_bank
        mrb_ram #(
            .WIDTH (8),
            .DEPTH (ROWS)
        ) u_bank (
            .i_clk     (i_clk),
            .i_wr_en   (bank_we[b]),
            .i_wr_addr (bank_wa[b]),
            .i_wr_data (bank_wd[b]),
            .i_rd_en   (i_cmd.accept),
            .i_rd_addr (rd_row[b]),
            .o_rd_data (bank_rd[b])
        );
    end

    // fifo control
    assign cmd_empty = (cmd_fill == '0);
    assign ext_empty = (ext_fill == '0);
    assign cmd_full  = (cmd_fill == FULL_CNT);
    assign ext_full  = (ext_fill == FULL_CNT);
    assign cmd_last  = (cmd_fill == CW'(1));
    assign ext_last  = (ext_fill == CW'(1));
    assign cmd_push  = i_cmd.commit && item_in_win && is_write && hit_cmd && !cmd_full;
    assign ext_push  = i_cmd.commit && item_in_win && is_write && hit_ext && !ext_full;
    assign cmd_pop   = i_cmd.commit && item_in_win && !is_write && hit_cmd && !cmd_empty;
    assign ext_pop   = i_cmd.commit && item_in_win && !is_write && hit_ext && !ext_empty;

    mrb_fifo #(.DEPTH(FIFO_DEPTH)) u_cmd_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (i_cmd.accept),
        .i_push      (cmd_push),
        .i_pop       (cmd_pop),
        .i_push_data (wdata),
        .o_head_data (cmd_head),
        .o_count     (cmd_fill)
    );

    mrb_fifo #(.DEPTH(FIFO_DEPTH)) u_ext_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (i_cmd.accept),
        .i_push      (ext_push),
        .i_pop       (ext_pop),
        .i_push_data (wdata),
        .o_head_data (ext_head),
        .o_count     (ext_fill)
    );

    // key word and pending byte overlays
    always_comb begin
        n_cfg_word  = r_cfg_word;
        n_pend_byte = r_pend_byte;
        if (i_cmd.commit && item_in_win && is_write) begin
            for (int i = 0; i < 4; i++) begin
                if (g_en[i] && g_addr[i] < ADR_CFG_END) begin
                    n_cfg_word[8*g_addr[i][1:0] +: 8] = wdata[8*i +: 8];
                end
                if (g_en[i] && g_addr[i] == ADR_PEND) begin
                    n_pend_byte = wdata[8*i +: 8];
                end
            end
            if (hit_cmd) n_pend_byte[BIT_CMD]     = 1'b1;
            if (hit_ext) n_pend_byte[BIT_CMD_EXT] = 1'b1;
        end
        if (cmd_pop && cmd_last) n_pend_byte[BIT_CMD]     = 1'b0;
        if (ext_pop && ext_last) n_pend_byte[BIT_CMD_EXT] = 1'b0;
    end

    // result beat
    always_comb begin
        n_out             = '0;
        n_out.irq_cmd     = !cmd_empty;
        n_out.irq_cmd_ext = !ext_empty;
        if (!item_in_win) begin
            n_out.status = STATUS_FAULT;
        end else if (!is_write) begin
            if (hit_cmd || hit_ext) begin
                if ((hit_cmd && cmd_empty) || (hit_ext && ext_empty)) begin
                    n_out.status = STATUS_FAULT;
                end else begin
                    n_out.read_data = (hit_cmd ? cmd_head : ext_head) & wmask;
                end
                if (hit_cmd && cmd_last) n_out.irq_cmd     = 1'b0;
                if (hit_ext && ext_last) n_out.irq_cmd_ext = 1'b0;
            end else begin
                n_out.read_data = gathered;
            end
        end else begin
            if ((hit_cmd && cmd_full) || (hit_ext && ext_full)) begin
                n_out.status = STATUS_FULL;
            end
            if (hit_cmd) n_out.irq_cmd     = 1'b1;
            if (hit_ext) n_out.irq_cmd_ext = 1'b1;
            if (hit_tx && r_cfg_word == SEND_KEY) begin
                n_out.send_valid = 1'b1;
                n_out.send_word  = wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row   <= '0;
            r_cfg_word  <= '0;
            r_pend_byte <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_row <= r_clr_row + 1'b1;
            end
            r_cfg_word  <= n_cfg_word;
            r_pend_byte <= n_pend_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_item <= i_in_data;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.clr_last = (r_clr_row == RW'(ROWS - 1));
    assign o_out_data      = r_out;
endmodule

// ----- rtl/core/mailbox_register_block.sv -----
// mailbox register block top level: controller and datapath
// depends on mrb_pkg, mrb_ctrl and mrb_datapath
//
// mailbox register block. each input beat is one bus access of 0 to 4 bytes
// (size codes above 4 act as 4), little-endian, into a byte window of
// WINDOW_BYTES bytes; each access gives exactly one result beat. the accept
// cycle reads all four byte-lane banks of the window and both fifo heads; the
// commit in the execute state after it applies the access and loads the result
// register. the next access is accepted as soon as that commit is done, while
// the result may still wait to be taken; a result that is not taken holds the
// commit of the following access. after reset the window banks are cleared one
// row of four bytes a cycle, with the input stalled. writes to 0x0c and 0x10
// push into the command and extended command fifos (FIFO_DEPTH words each) and
// set pending bits 2 and 3 at 0x20; reads of those offsets pop. a write to 0x4
// while the word at 0x0 holds the send key raises send_valid with the written
// word.
module mailbox_register_block #(
    parameter int WINDOW_BYTES = mrb_pkg::WINDOW_BYTES_DEF,
    parameter int FIFO_DEPTH   = mrb_pkg::FIFO_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // access channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mrb_pkg::t_in_beat  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output mrb_pkg::t_out_beat o_out_data
);
    import mrb_pkg::*;

    // command and status between controller and datapath
    t_mrb_cmd  cmd;
    t_mrb_stat stat;

    // sequencing: clearing pass, accept, commit, result valid
    mrb_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // window banks, overlays, fifos and the result register
    mrb_datapath #(
        .WINDOW_BYTES (WINDOW_BYTES),
        .FIFO_DEPTH   (FIFO_DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );
endmodule

// ----- rtl/core/mrb_checker.sv -----
// port-level checks for the mailbox register block, bound to the top level
// depends on mrb_pkg and mailbox_register_block
module mrb_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input mrb_pkg::t_in_beat  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input mrb_pkg::t_out_beat o_out_data
);
    import mrb_pkg::*;

    // a stalled result beat stays and holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // one access at a time: the cycle after an accept takes no beat
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("access accepted while the previous one is at work");

    // a fault returns no data and sends nothing
    a_fault_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == STATUS_FAULT |->
            o_out_data.read_data == '0 && !o_out_data.send_valid)
        else $error("faulted access returned data or sent a message");

    // no send word without a send, and a send never reports a fault
    a_send_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.send_valid || o_out_data.send_word == '0) &&
            (!o_out_data.send_valid || o_out_data.status == STATUS_OK))
        else $error("send word without a valid send");
endmodule

bind mailbox_register_block mrb_checker u_mrb_checker (.*);

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// self-checking testbench for mailbox_register_block: scoreboard class plus driver tasks
// depends on mrb_pkg and the mailbox_register_block rtl
module testbench;
    import mrb_pkg::*;

    localparam int unsigned WIN_BYTES     = WINDOW_BYTES_DEF;
    localparam int unsigned FIFO_WORDS    = FIFO_DEPTH_DEF;
    localparam int unsigned CFG_OFS       = 0;       // key word lives at the start of the window
    localparam int unsigned RANDOM_ITEMS  = 1800;
    localparam int unsigned HOLD_CYCLES   = 300;     // long result-side hold-off
    localparam int unsigned SETTLE_CYCLES = 8;       // settling margin after the last access
    localparam int unsigned CYCLE_LIMIT   = 900000;

    // scoreboard: own copy of the window, both fifos and the irq lines;
    // every accepted access queues the result it must produce
    class mailbox_checker;
        logic [7:0]  win_mem [WIN_BYTES];
        logic [31:0] cmd_words [$];
        logic [31:0] ext_words [$];
        logic        cmd_line;
        logic        ext_line;
        t_out_beat   awaited [$];
        int unsigned failures;

        function new();
            foreach (win_mem[i]) win_mem[i] = 8'h00;
            cmd_line = 1'b0;
            ext_line = 1'b0;
            failures = 0;
        endfunction

        // little-endian read, bytes past the window end read as zero
        function logic [31:0] window_span(int unsigned base, int unsigned n);
            logic [31:0] v;
            int unsigned k;
            v = '0;
            for (k = 0; k < n; k++)
                if (base + k < WIN_BYTES) v[8*k +: 8] = win_mem[base + k];
            return v;
        endfunction

        function t_out_beat mailbox_effect(t_in_beat b);
            t_out_beat   r;
            int unsigned n;
            int unsigned base;
            int unsigned k;
            int unsigned depth;
            int          pend_pos;
            logic [31:0] keep;
            logic [31:0] wdata;
            logic        is_fifo;
            logic        is_ext;
            r        = '0;
            n        = (b.size_bytes > 3'd4) ? 4 : 32'(b.size_bytes);
            keep     = (n == 4) ? 32'hFFFF_FFFF : (32'h1 << (8 * n)) - 32'h1;
            wdata    = b.write_data & keep;
            base     = 32'(b.offset);
            is_ext   = (b.offset == OFS_CMD_EXT);
            is_fifo  = (b.offset == OFS_CMD) || is_ext;
            depth    = is_ext ? ext_words.size() : cmd_words.size();
            pend_pos = is_ext ? BIT_CMD_EXT : BIT_CMD;
            if (base >= WIN_BYTES) begin
                r.status = STATUS_FAULT;
            end else if (b.op == OP_READ) begin
                if (!is_fifo) begin
                    r.read_data = window_span(base, n);
                end else if (depth == 0) begin
                    r.status = STATUS_FAULT;
                end else begin
                    if (is_ext) r.read_data = ext_words.pop_front() & keep;
                    else r.read_data = cmd_words.pop_front() & keep;
                    if (depth == 1) begin
                        if (is_ext) ext_line = 1'b0;
                        else cmd_line = 1'b0;
                        win_mem[ADR_PEND][pend_pos] = 1'b0;
                    end
                end
            end else begin
                for (k = 0; k < n; k++)
                    if (base + k < WIN_BYTES) win_mem[base + k] = wdata[8*k +: 8];
                if (b.offset == OFS_TXCMD && window_span(CFG_OFS, 4) == SEND_KEY) begin
                    r.send_valid = 1'b1;
                    r.send_word  = wdata;
                end
                if (is_fifo) begin
                    if (depth >= FIFO_WORDS) r.status = STATUS_FULL;
                    else if (is_ext) ext_words.insert(ext_words.size(), wdata);
                    else cmd_words.insert(cmd_words.size(), wdata);
                    if (is_ext) ext_line = 1'b1;
                    else cmd_line = 1'b1;
                    win_mem[ADR_PEND][pend_pos] = 1'b1;
                end
            end
            r.irq_cmd     = cmd_line;
            r.irq_cmd_ext = ext_line;
            return r;
        endfunction

        function void flag(string what);
            if (failures < 10) $display("%0t: %s", $time, what);
            failures++;
        endfunction

        function void note_access(t_in_beat b);
            awaited.insert(awaited.size(), mailbox_effect(b));
        endfunction

        function void check_result(t_out_beat got);
            t_out_beat want;
            logic      bad;
            if (awaited.size() == 0) begin
                flag($sformatf("result beat with nothing outstanding: st=%0d rd=%h",
                               got.status, got.read_data));
            end else begin
                want = awaited.pop_front();
                bad = (got.status !== want.status) || (got.read_data !== want.read_data) ||
                      (got.irq_cmd !== want.irq_cmd) || (got.irq_cmd_ext !== want.irq_cmd_ext) ||
                      (got.send_valid !== want.send_valid) || (got.send_word !== want.send_word);
                if (bad)
                    flag($sformatf({"result mismatch, want st=%0d rd=%h irq=%b%b tx=%b:%h",
                                    " got st=%0d rd=%h irq=%b%b tx=%b:%h"},
                                   want.status, want.read_data, want.irq_cmd, want.irq_cmd_ext,
                                   want.send_valid, want.send_word,
                                   got.status, got.read_data, got.irq_cmd, got.irq_cmd_ext,
                                   got.send_valid, got.send_word));
            end
        endfunction

        function void check_leftovers();
            if (awaited.size() != 0)
                flag($sformatf("%0d result beats never arrived", awaited.size()));
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       i_out_stall;
    t_in_beat   i_in_data;
    logic       o_in_stall;
    logic       o_out_valid;
    t_out_beat  o_out_data;

    mailbox_checker book;
    int unsigned    sent_count;
    int unsigned    quiet_left;     // sender beats still to go with no gap
    int unsigned    cycle_count;

    mailbox_register_block u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // idle length: mostly none, some short, a few long
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // access size: mostly full words, the rest anything the field holds
    function automatic int unsigned draw_size();
        if ($urandom_range(9) < 6) return 4;
        return $urandom_range(0, 7);
    endfunction

    // one access beat: optional idle gap first, then hold valid until taken;
    // valid is left high so back-to-back beats never drop it
    task automatic issue(input logic op, input int unsigned ofs, input int unsigned sz,
                         input logic [31:0] data);
        t_in_beat    b;
        int unsigned gap;
        gap = (quiet_left > 0) ? 0 : draw_gap();
        if (quiet_left > 0) quiet_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        b.op         = op;
        b.offset     = ofs[OFFSET_W-1:0];
        b.size_bytes = sz[SIZE_W-1:0];
        b.write_data = data;
        i_in_data  <= b;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        book.note_access(b);
        sent_count++;
    endtask

    // drop valid and wait until every queued result has been taken
    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (book.awaited.size() != 0);
    endtask

    // result side: take beats, random stalls with quiet stretches, and two
    // long hold-offs so the block backs up and stalls its input
    initial begin : result_side
        int unsigned stall_left;
        int unsigned quiet_run;
        int unsigned hold_left;
        int unsigned taken;
        stall_left = 0;
        quiet_run  = 0;
        hold_left  = 0;
        taken      = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
                book.check_result(o_out_data);
                taken++;
                if (taken == 200 || taken == 1300) hold_left = HOLD_CYCLES;
            end
            if (stall_left == 0 && quiet_run == 0) begin
                if ($urandom_range(19) == 0) quiet_run = $urandom_range(20, 80);
                else stall_left = draw_gap();
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (quiet_run > 0) begin
                quiet_run--;
                i_out_stall <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // run limit
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin : access_side
        int unsigned kind;
        int unsigned k;
        int unsigned reps;
        int unsigned pushes;
        int unsigned pops;
        int unsigned fifo_ofs;
        logic [31:0] key;
        logic [31:0] data;
        logic        paused;
        book       = new();
        sent_count = 0;
        quiet_left = 0;
        paused     = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block stalls its input during the window clearing pass

        // directed part
        issue(OP_READ, CFG_OFS, 4, 32'h0);                  // cleared window
        issue(OP_READ, 32'(OFS_CMD), 4, 32'h0);             // pop of an empty fifo
        issue(OP_READ, WIN_BYTES, 4, 32'h0);                // first offset out of window
        issue(OP_WRITE, 32'h1FFF, 7, 32'hFFFF_FFFF);        // last offset, oversize
        issue(OP_WRITE, CFG_OFS, 4, SEND_KEY);
        issue(OP_WRITE, 32'(OFS_TXCMD), 0, 32'hFFFF_FFFF);  // send with no bytes written
        issue(OP_WRITE, 32'(OFS_TXCMD), 7, 32'hDEAD_BEEF);  // oversize acts as a word
        issue(OP_WRITE, CFG_OFS, 1, 32'hFFFF_FF00);         // breaks the key
        issue(OP_WRITE, 32'(OFS_TXCMD), 4, 32'h1234_5678);  // no send
        issue(OP_WRITE, WIN_BYTES - 2, 4, 32'h1122_3344);   // runs past the window end
        issue(OP_READ, WIN_BYTES - 2, 4, 32'h0);
        issue(OP_READ, WIN_BYTES - 1, 0, 32'h0);
        // fill the extended fifo one past full, sizes cycling through all codes
        for (k = 0; k <= FIFO_WORDS; k++)
            issue(OP_WRITE, 32'(OFS_CMD_EXT), k % 8, $urandom);
        issue(OP_READ, 32'(ADR_PEND), 1, 32'h0);            // pending byte, only the extended bit set
        issue(OP_WRITE, 32'(OFS_CMD), 2, 32'hA5A5_C3C3);
        issue(OP_READ, 32'(OFS_CMD), 4, 32'h0);             // pop to empty drops irq
        drain();

        // random part, built from short sequences
        while (sent_count < RANDOM_ITEMS + 32) begin
            if ($urandom_range(9) == 0) quiet_left = $urandom_range(20, 80);
            if (!paused && sent_count >= 900) begin
                paused = 1'b1;
                drain();
            end
            kind = $urandom_range(99);
            if (kind < 30) begin
                // fifo burst: pushes then pops, often reaching full and empty
                fifo_ofs = $urandom_range(1) ? 32'(OFS_CMD_EXT) : 32'(OFS_CMD);
                pushes = $urandom_range(0, 20);
                pops   = $urandom_range(0, 20);
                for (k = 0; k < pushes; k++) begin
                    issue(OP_WRITE, fifo_ofs, draw_size(), $urandom);
                    if ($urandom_range(7) == 0)
                        issue(OP_READ, 32'(ADR_PEND), draw_size(), $urandom);
                end
                for (k = 0; k < pops; k++)
                    issue(OP_READ, fifo_ofs, draw_size(), $urandom);
            end else if (kind < 52) begin
                // send sequence: key as a word, bytes or halves, now and then one bit off
                key = SEND_KEY;
                if ($urandom_range(7) == 0) key = key ^ (32'h1 << $urandom_range(31));
                case ($urandom_range(3))
                    0: begin
                        issue(OP_WRITE, CFG_OFS, 4, key);
                    end
                    1: begin
                        for (k = 0; k < 4; k++) begin
                            data = $urandom;
                            data[7:0] = key[8*k +: 8];
                            issue(OP_WRITE, CFG_OFS + k, 1, data);
                        end
                    end
                    2: begin
                        issue(OP_WRITE, CFG_OFS, 2, {16'($urandom), key[15:0]});
                        issue(OP_WRITE, CFG_OFS + 2, 2, {16'($urandom), key[31:16]});
                    end
                    default: begin
                        // keep whatever the key word holds now
                    end
                endcase
                reps = $urandom_range(1, 3);
                for (k = 0; k < reps; k++)
                    issue(OP_WRITE, 32'(OFS_TXCMD), draw_size(), $urandom);
                if ($urandom_range(3) == 0) issue(OP_READ, $urandom_range(0, 7), draw_size(), 0);
            end else if (kind < 60) begin
                // near the window end
                issue(1'($urandom_range(1)), $urandom_range(WIN_BYTES - 8, WIN_BYTES - 1),
                      $urandom_range(0, 7), $urandom);
            end else if (kind < 68) begin
                // out of window
                issue(1'($urandom_range(1)), $urandom_range(WIN_BYTES, 8191), draw_size(),
                      $urandom);
            end else if (kind < 84) begin
                // register area: config, pending byte and neighbors of the fifo ports
                issue(1'($urandom_range(1)), $urandom_range(0, 8'h27), draw_size(), $urandom);
            end else begin
                issue(1'($urandom_range(1)), $urandom_range(0, WIN_BYTES - 1), draw_size(),
                      $urandom);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        book.check_leftovers();
        if (book.failures == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
